// File: sv/psb_pkg.sv
// Shared types and constants for the positional insert sequence buffer.
// Used by psb_cell, psb_row and the top level; no dependencies.
`default_nettype none

package psb_pkg;

  localparam int unsigned CAPACITY_DEF = 32;
  localparam int unsigned POS_W        = 6;
  localparam int unsigned ELEM_W       = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 40;

  typedef enum logic [1:0] {
    ST_LIST    = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_t;

  typedef enum logic [1:0] {
    ROW_HOLD   = 2'd0,
    ROW_INSERT = 2'd1,
    ROW_ROT_L  = 2'd2,
    ROW_ROT_R  = 2'd3
  } row_op_t;

  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_FWD  = 2'd1,
    S_BWD  = 2'd2
  } state_t;

  typedef struct packed {
    row_op_t          op;
    logic [POS_W-1:0] pos;
    logic [POS_W-1:0] count;
  } row_ctl_t;

endpackage

`default_nettype wire

// File: sv/positional_insert_sequence_buffer.sv
// A rejected insert gives its single result in the cycle after the transfer.
// A valid insert is written into the cell row, then emits 2*count results,
// one per cycle while out_tready is high; the next item is taken after the last.
// The rate is set by the cell row, which rotates one element per cycle while
// out_tready is high. Reset clears the count and the sequencer; cell contents
// are not reset.
`default_nettype none

module positional_insert_sequence_buffer #(
  parameter int unsigned CAPACITY = psb_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_tvalid,
  output logic                                  in_tready,
  // position [5:0], value [37:6], zero pad [39:38]
  input  wire logic [psb_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  // status [1:0], direction [2], element [34:3], pass_end [35], zero pad [39:36]
  output logic      [psb_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic                                  out_tlast
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  psb_pkg::state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;

  logic                               out_valid_r, out_valid_nxt;
  psb_pkg::status_t                   out_status_r, out_status_nxt;
  logic                               out_dir_r, out_dir_nxt;
  logic [psb_pkg::ELEM_W-1:0]         out_elem_r, out_elem_nxt;
  logic                               out_pend_r, out_pend_nxt;
  logic                               out_last_r, out_last_nxt;

  logic [psb_pkg::POS_W-1:0]  in_pos;
  logic [psb_pkg::ELEM_W-1:0] in_value;
  logic                       load_ok;
  logic                       in_xfer;
  logic                       bad_pos;
  logic                       full;
  logic                       step_end;

  psb_pkg::row_ctl_t          row_ctl;
  logic [psb_pkg::ELEM_W-1:0] head, tail;

  assign in_pos   = in_tdata[psb_pkg::POS_W-1:0];
  assign in_value = in_tdata[psb_pkg::POS_W +: psb_pkg::ELEM_W];
  assign load_ok  = !out_valid_r || out_tready;
  assign in_tready = (state_r == psb_pkg::S_IDLE) && load_ok;
  assign in_xfer  = in_tvalid && in_tready;
  assign bad_pos  = in_pos > psb_pkg::POS_W'(count_r);
  assign full     = count_r == CNT_W'(CAPACITY);
  assign step_end = idx_r == (count_r - CNT_W'(1));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psb_pkg::S_IDLE: begin
        if (in_xfer && !bad_pos && !full) begin
          state_nxt = psb_pkg::S_FWD;
        end
      end
      psb_pkg::S_FWD: begin
        if (load_ok && step_end) begin
          state_nxt = psb_pkg::S_BWD;
        end
      end
      psb_pkg::S_BWD: begin
        if (load_ok && step_end) begin
          state_nxt = psb_pkg::S_IDLE;
        end
      end
      default: state_nxt = psb_pkg::S_IDLE;
    endcase
  end

  // datapath control and output stage
  always_comb begin
    count_nxt      = count_r;
    idx_nxt        = idx_r;
    row_ctl.op     = psb_pkg::ROW_HOLD;
    row_ctl.pos    = in_pos;
    row_ctl.count  = psb_pkg::POS_W'(count_r);
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_dir_nxt    = out_dir_r;
    out_elem_nxt   = out_elem_r;
    out_pend_nxt   = out_pend_r;
    out_last_nxt   = out_last_r;
    unique case (state_r)
      psb_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (bad_pos || full) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = bad_pos ? psb_pkg::ST_INVALID : psb_pkg::ST_FULL;
            out_dir_nxt    = 1'b0;
            out_elem_nxt   = '0;
            out_pend_nxt   = 1'b0;
            out_last_nxt   = 1'b1;
          end else begin
            row_ctl.op = psb_pkg::ROW_INSERT;
            count_nxt  = count_r + CNT_W'(1);
            idx_nxt    = '0;
          end
        end
      end
      psb_pkg::S_FWD: begin
        if (load_ok) begin
          row_ctl.op     = psb_pkg::ROW_ROT_L;
          out_valid_nxt  = 1'b1;
          out_status_nxt = psb_pkg::ST_LIST;
          out_dir_nxt    = 1'b0;
          out_elem_nxt   = head;
          out_pend_nxt   = step_end;
          out_last_nxt   = 1'b0;
          idx_nxt        = step_end ? '0 : idx_r + CNT_W'(1);
        end
      end
      psb_pkg::S_BWD: begin
        if (load_ok) begin
          row_ctl.op     = psb_pkg::ROW_ROT_R;
          out_valid_nxt  = 1'b1;
          out_status_nxt = psb_pkg::ST_LIST;
          out_dir_nxt    = 1'b1;
          out_elem_nxt   = tail;
          out_pend_nxt   = step_end;
          out_last_nxt   = step_end;
          idx_nxt        = step_end ? '0 : idx_r + CNT_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= psb_pkg::S_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_status_r <= out_status_nxt;
    out_dir_r    <= out_dir_nxt;
    out_elem_r   <= out_elem_nxt;
    out_pend_r   <= out_pend_nxt;
    out_last_r   <= out_last_nxt;
  end

  psb_row #(
    .CAPACITY (CAPACITY)
  ) u_row (
    .clk       (clk),
    .ctl       (row_ctl),
    .new_value (in_value),
    .head      (head),
    .tail      (tail)
  );

  assign out_tvalid = out_valid_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {4'b0000, out_pend_r, out_elem_r, out_dir_r, out_status_r};

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && !bad_pos && !full |=> count_r == $past(count_r) + CNT_W'(1))
    else $error("valid insert did not grow the count");

  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_status_r != psb_pkg::ST_LIST |-> out_tlast && !out_pend_r)
    else $error("rejected insert result not marked last");

  a_last_is_back_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tlast && out_status_r == psb_pkg::ST_LIST |-> out_dir_r && out_pend_r)
    else $error("listing ended outside the back-to-front pass end");

  a_busy_no_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != psb_pkg::S_IDLE |-> !in_tready)
    else $error("input taken during a listing");
`endif

endmodule

`default_nettype wire

// File: sv/psb_cell.sv
// One storage cell of the sequence row: holds a single element.
// Depends on psb_pkg for the cell operation codes.
`default_nettype none

module psb_cell (
  input  wire logic                          clk,
  input  wire psb_pkg::cell_op_t             op,
  input  wire logic [psb_pkg::ELEM_W-1:0]    left_in,
  input  wire logic [psb_pkg::ELEM_W-1:0]    right_in,
  input  wire logic [psb_pkg::ELEM_W-1:0]    new_in,
  output logic      [psb_pkg::ELEM_W-1:0]    value_q
);

  logic [psb_pkg::ELEM_W-1:0] val_r;
  logic [psb_pkg::ELEM_W-1:0] val_nxt;

  always_comb begin
    case (op)
      psb_pkg::CELL_LOAD:  val_nxt = new_in;
      psb_pkg::CELL_LEFT:  val_nxt = left_in;
      psb_pkg::CELL_RIGHT: val_nxt = right_in;
      default:             val_nxt = val_r;
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign value_q = val_r;

endmodule

`default_nettype wire

// File: sv/psb_row.sv
// Row of CAPACITY cells; inserts by shifting the tail back one cell and
// rotates within the held count for listing. Depends on psb_pkg, psb_cell.
`default_nettype none

module psb_row #(
  parameter int unsigned CAPACITY = psb_pkg::CAPACITY_DEF
) (
  input  wire logic                         clk,
  input  wire psb_pkg::row_ctl_t            ctl,
  input  wire logic [psb_pkg::ELEM_W-1:0]   new_value,
  output logic      [psb_pkg::ELEM_W-1:0]   head,
  output logic      [psb_pkg::ELEM_W-1:0]   tail
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic [psb_pkg::ELEM_W-1:0] v [CAPACITY];
  logic [psb_pkg::POS_W-1:0]  cnt_m1;

  assign cnt_m1 = ctl.count - psb_pkg::POS_W'(1);
  assign head   = v[0];
  assign tail   = v[cnt_m1[IDX_W-1:0]];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    psb_pkg::cell_op_t          op;
    logic [psb_pkg::ELEM_W-1:0] left_in;
    logic [psb_pkg::ELEM_W-1:0] right_in;

    // wrap the ring at the front and at the last held element
    if (i == 0) begin : g_first
      assign left_in = tail;
    end else begin : g_mid
      assign left_in = v[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_in = v[0];
    end else begin : g_inner
      assign right_in = (cnt_m1 == psb_pkg::POS_W'(i)) ? v[0] : v[i+1];
    end

    always_comb begin
      case (ctl.op)
        psb_pkg::ROW_INSERT: begin
          if (psb_pkg::POS_W'(i) == ctl.pos) begin
            op = psb_pkg::CELL_LOAD;
          end else if (psb_pkg::POS_W'(i) > ctl.pos) begin
            op = psb_pkg::CELL_LEFT;
          end else begin
            op = psb_pkg::CELL_HOLD;
          end
        end
        psb_pkg::ROW_ROT_L: op = psb_pkg::CELL_RIGHT;
        psb_pkg::ROW_ROT_R: op = psb_pkg::CELL_LEFT;
        default:            op = psb_pkg::CELL_HOLD;
      endcase
    end

    psb_cell u_cell (
      .clk      (clk),
      .op       (op),
      .left_in  (left_in),
      .right_in (right_in),
      .new_in   (new_value),
      .value_q  (v[i])
    );
  end

endmodule

`default_nettype wire
